[design/ranked_topk_table_with_dedup_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ranked top-k table
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RANKED_TOPK_TABLE_WITH_DEDUP_CORE_MACROS_SVH
`define RANKED_TOPK_TABLE_WITH_DEDUP_CORE_MACROS_SVH

// same-cycle implication
`define RTKD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RTKD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rtkd_pkg.sv]
// ----------------------------------------------------------------------------
// rtkd_pkg
// Types, codes and constants shared by the ranked top-k table and its cells.
// ----------------------------------------------------------------------------
package rtkd_pkg;

	localparam int DEF_MAX_ENTRIES = 64;

	localparam int KEY_W      = 32;
	localparam int FIT_W      = 32;
	localparam int GROUP_W    = 16;
	localparam int CAP_W      = 7;
	localparam int STATUS_W   = 2;
	localparam int POS_W      = 6;
	localparam int TOTAL_W    = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_WORSE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUP   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_GROUP = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_POP_ID   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd1;

	typedef struct packed {
		logic               func;
		logic [GROUP_W-1:0] group_id;
		logic [KEY_W-1:0]   structure_key;
		logic [FIT_W-1:0]   fitness;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic                replaced_duplicate;
		logic                evicted_worst;
		logic [TOTAL_W-1:0]  entry_total;
		logic                is_full_flag;
		logic [FIT_W-1:0]    best_score;
		logic [FIT_W-1:0]    worst_score;
	} res_t;

	typedef struct packed {
		logic             load;
		logic             rem;
		logic [KEY_W-1:0] key;
		logic [FIT_W-1:0] fitness;
	} cell_cmd_t;

	typedef struct packed {
		logic key_hit;
		logic fit_le;
		logic fit_ge;
		logic is_last;
	} cell_flags_t;

endpackage

[design/rtkd_cell.sv]
// ----------------------------------------------------------------------------
// rtkd_cell
// One rank of the table: holds a key and a fitness, compares them against the
// broadcast request and takes its left neighbour's entry on a shifted insert.
// ----------------------------------------------------------------------------
module rtkd_cell #(
	parameter int MAX_ENTRIES = rtkd_pkg::DEF_MAX_ENTRIES,
	parameter int IDX         = 0
) (
	input  logic                                clk,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]    count,
	input  rtkd_pkg::cell_cmd_t                 cmd,
	input  logic [$clog2(MAX_ENTRIES)-1:0]      ins_idx,
	input  logic [$clog2(MAX_ENTRIES)-1:0]      rem_idx,
	input  logic [rtkd_pkg::KEY_W-1:0]          prev_key,
	input  logic [rtkd_pkg::FIT_W-1:0]          prev_fit,
	output logic [rtkd_pkg::KEY_W-1:0]          key_q,
	output logic [rtkd_pkg::FIT_W-1:0]          fit_q,
	output rtkd_pkg::cell_flags_t               flags
);
	import rtkd_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES+1);
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam logic [IDX_W-1:0] MY_POS  = IDX_W'(IDX);
	localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

	logic valid;

	assign valid         = MY_CNT < count;
	assign flags.key_hit = valid && (key_q == cmd.key);
	assign flags.fit_le  = valid && (fit_q <= cmd.fitness);
	assign flags.fit_ge  = valid && (fit_q >= cmd.fitness);
	assign flags.is_last = MY_NEXT == count;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (MY_POS == ins_idx) begin
				key_q <= cmd.key;
				fit_q <= cmd.fitness;
			end else if (MY_POS > ins_idx && !(cmd.rem && MY_POS > rem_idx)) begin
				key_q <= prev_key;
				fit_q <= prev_fit;
			end
		end
	end

endmodule

[design/ranked_topk_table_with_dedup_core.sv]
// ----------------------------------------------------------------------------
// ranked_topk_table_with_dedup_core
// A request steps through compare, update and result register before done
// rises; results cannot be stalled by the receiver. busy covers the compare
// and update passes over the cell row; the next request is taken once busy
// falls, as the last result is registered. Reset empties the table (count 0),
// population_id 0 and capacity 64; cell contents are not cleared.
// ----------------------------------------------------------------------------
`include "ranked_topk_table_with_dedup_core_macros.svh"

module ranked_topk_table_with_dedup_core #(
	parameter int MAX_ENTRIES = rtkd_pkg::DEF_MAX_ENTRIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  rtkd_pkg::req_t                    req,
	output logic                              done,
	output rtkd_pkg::res_t                    result,
	input  logic                              cfg_we,
	input  logic [rtkd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtkd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rtkd_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES+1);
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;
	localparam int TW    = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;
	typedef enum logic [1:0] {OP_HOLD, OP_CLEAR, OP_INSERT} op_t;

	state_t               state_q;
	op_t                  op_q;
	req_t                 req_q;
	res_t                 result_q;
	logic                 done_q;
	logic                 res_pend_q;
	logic [CNT_W-1:0]     count_q;
	logic [GROUP_W-1:0]   pop_q;
	logic [CAP_W-1:0]     cap_q;
	logic [STATUS_W-1:0]  st_q;
	logic [IDX_W-1:0]     pos_q;
	logic [IDX_W-1:0]     ridx_q;
	logic                 rem_q;
	logic                 ev_q;

	cell_cmd_t            cmd;
	cell_flags_t          flags [MAX_ENTRIES];
	logic [KEY_W-1:0]     cell_key [MAX_ENTRIES];
	logic [FIT_W-1:0]     cell_fit [MAX_ENTRIES];

	logic [MAX_ENTRIES-1:0] m_v, le_v, ge_v, last_v, ins_v, rem_v, dup_v;
	logic [IDX_W-1:0]       ins_idx_c, rem_idx_c;
	logic [FIT_W-1:0]       worst_c;
	logic                   full_c;
	logic [CW-1:0]          new_cap_c;
	logic [PW-1:0]          pos_ext;
	logic [TW-1:0]          total_ext;

	function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] c);
		logic [CW-1:0] e;
		e = CW'(c);
		if (c == '0) begin
			e = CW'(1);
		end else if (e > CW'(MAX_ENTRIES)) begin
			e = CW'(MAX_ENTRIES);
		end
		return e;
	endfunction

	assign cmd.load    = (state_q == S_UPD) && (op_q == OP_INSERT);
	assign cmd.rem     = rem_q;
	assign cmd.key     = req_q.structure_key;
	assign cmd.fitness = req_q.fitness;

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_head
			rtkd_cell #(.MAX_ENTRIES(MAX_ENTRIES), .IDX(g)) u_cell (
				.clk      (clk),
				.count    (count_q),
				.cmd      (cmd),
				.ins_idx  (pos_q),
				.rem_idx  (ridx_q),
				.prev_key ('0),
				.prev_fit ('0),
				.key_q    (cell_key[g]),
				.fit_q    (cell_fit[g]),
				.flags    (flags[g])
			);
		end else begin : g_body
			rtkd_cell #(.MAX_ENTRIES(MAX_ENTRIES), .IDX(g)) u_cell (
				.clk      (clk),
				.count    (count_q),
				.cmd      (cmd),
				.ins_idx  (pos_q),
				.rem_idx  (ridx_q),
				.prev_key (cell_key[g-1]),
				.prev_fit (cell_fit[g-1]),
				.key_q    (cell_key[g]),
				.fit_q    (cell_fit[g]),
				.flags    (flags[g])
			);
		end
		assign m_v[g]    = flags[g].key_hit;
		assign le_v[g]   = flags[g].fit_le;
		assign ge_v[g]   = flags[g].fit_ge;
		assign last_v[g] = flags[g].is_last;
	end

	always_comb begin
		ins_v[0] = !le_v[0];
		for (int i = 1; i < MAX_ENTRIES; i++) begin
			ins_v[i] = !le_v[i] && le_v[i-1];
		end
		rem_v = m_v & ~le_v;
		dup_v = m_v & le_v;
	end

	always_comb begin
		ins_idx_c = '0;
		rem_idx_c = '0;
		worst_c   = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (ins_v[i]) begin
				ins_idx_c = ins_idx_c | IDX_W'(i);
			end
			if (rem_v[i]) begin
				rem_idx_c = rem_idx_c | IDX_W'(i);
			end
			worst_c = worst_c | (cell_fit[i] & {FIT_W{last_v[i]}});
		end
	end

	assign full_c    = CW'(count_q) >= eff_cap(cap_q);
	assign new_cap_c = eff_cap(cfg_data[CAP_W-1:0]);
	assign pos_ext   = PW'(pos_q);
	assign total_ext = TW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_HOLD;
			req_q      <= '0;
			result_q   <= '0;
			done_q     <= 1'b0;
			res_pend_q <= 1'b0;
			count_q    <= '0;
			pop_q      <= '0;
			cap_q      <= CAP_RESET;
			st_q       <= ST_OK;
			pos_q      <= '0;
			ridx_q     <= '0;
			rem_q      <= 1'b0;
			ev_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_POP_ID: begin
						pop_q <= cfg_data[GROUP_W-1:0];
					end
					CFG_CAPACITY: begin
						cap_q <= cfg_data[CAP_W-1:0];
						if (CW'(count_q) > new_cap_c) begin
							count_q <= CNT_W'(new_cap_c);
						end
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (res_pend_q) begin
						res_pend_q                  <= 1'b0;
						done_q                      <= 1'b1;
						result_q.status             <= st_q;
						result_q.position           <= pos_ext[POS_W-1:0];
						result_q.replaced_duplicate <= rem_q;
						result_q.evicted_worst      <= ev_q;
						result_q.entry_total        <= total_ext[TOTAL_W-1:0];
						result_q.is_full_flag       <= full_c;
						result_q.best_score  <= (count_q == '0) ? '1 : cell_fit[0];
						result_q.worst_score <= (count_q == '0) ? '1 : worst_c;
					end
					if (start) begin
						req_q   <= req;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					op_q    <= OP_HOLD;
					rem_q   <= 1'b0;
					ev_q    <= 1'b0;
					pos_q   <= '0;
					ridx_q  <= rem_idx_c;
					state_q <= S_UPD;
					if (req_q.func == FUNC_CLEAR) begin
						op_q <= OP_CLEAR;
						st_q <= ST_OK;
					end else if (req_q.group_id != pop_q) begin
						st_q <= ST_GROUP;
					end else if (full_c && !(|ge_v)) begin
						st_q <= ST_WORSE;
					end else if (|dup_v) begin
						st_q <= ST_DUP;
					end else if (full_c && !(|(ge_v & ~le_v))) begin
						st_q <= ST_WORSE;
					end else begin
						op_q  <= OP_INSERT;
						st_q  <= ST_OK;
						pos_q <= ins_idx_c;
						rem_q <= |rem_v;
						ev_q  <= !(|rem_v) && full_c;
					end
				end
				S_UPD: begin
					case (op_q)
						OP_CLEAR: begin
							count_q <= '0;
						end
						OP_INSERT: begin
							if (!rem_q && !ev_q) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						default: begin
						end
					endcase
					res_pend_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

	`RTKD_ASSERT_NEXT(a_accept_to_cmp, start && !busy, state_q == S_CMP, "request not taken")
	`RTKD_ASSERT_IMPL(a_ins_onehot, state_q == S_CMP, $onehot0(ins_v), "table out of order")
	`RTKD_ASSERT_IMPL(a_key_unique, state_q == S_CMP, $onehot0(m_v), "duplicate key held")
	`RTKD_ASSERT_IMPL(a_rem_xor_evict, state_q == S_UPD, !(rem_q && ev_q), "remove and evict")
	`RTKD_ASSERT_NEXT(a_pend_to_done, res_pend_q, done_q && !res_pend_q, "result lost")

endmodule
